>>> hw/rtl/sie_pkg.sv
package sie_pkg;

  // Machine word width of the SIC architecture.
  localparam int unsigned WordBits = 24;

  // Opcode bytes in the SIC encoding.
  localparam logic [7:0] FuncAdd  = 8'h18;
  localparam logic [7:0] FuncSub  = 8'h1C;
  localparam logic [7:0] FuncMul  = 8'h20;
  localparam logic [7:0] FuncDiv  = 8'h24;
  localparam logic [7:0] FuncAnd  = 8'h40;
  localparam logic [7:0] FuncOr   = 8'h44;
  localparam logic [7:0] FuncComp = 8'h28;
  localparam logic [7:0] FuncTix  = 8'h2C;
  localparam logic [7:0] FuncJ    = 8'h3C;
  localparam logic [7:0] FuncJeq  = 8'h30;
  localparam logic [7:0] FuncJgt  = 8'h34;
  localparam logic [7:0] FuncJlt  = 8'h38;
  localparam logic [7:0] FuncJsub = 8'h48;
  localparam logic [7:0] FuncRsub = 8'h4C;
  localparam logic [7:0] FuncLda  = 8'h00;
  localparam logic [7:0] FuncLdx  = 8'h04;
  localparam logic [7:0] FuncLdl  = 8'h08;
  localparam logic [7:0] FuncLdch = 8'h50;
  localparam logic [7:0] FuncSta  = 8'h0C;
  localparam logic [7:0] FuncStx  = 8'h10;
  localparam logic [7:0] FuncStl  = 8'h14;
  localparam logic [7:0] FuncStsw = 8'hE8;
  localparam logic [7:0] FuncStch = 8'h54;
  localparam logic [7:0] FuncTd   = 8'hE0;
  localparam logic [7:0] FuncRd   = 8'hD8;
  localparam logic [7:0] FuncWd   = 8'hDC;

  // Status word codes written by compares.
  localparam logic [WordBits-1:0] SwEqual   = 24'h000001;
  localparam logic [WordBits-1:0] SwGreater = 24'h000002;
  localparam logic [WordBits-1:0] SwLess    = 24'h000004;

  // Masks used by the byte instructions.
  localparam logic [WordBits-1:0] HighMask = 24'hFFFF00;
  localparam logic [WordBits-1:0] LowMask  = 24'h0000FF;

  // Store request kinds.
  localparam logic [1:0] StoreNone = 2'd0;
  localparam logic [1:0] StoreWord = 2'd1;
  localparam logic [1:0] StoreByte = 2'd2;

  // Decoded operation classes passed from decode to execute.
  typedef enum logic [4:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_COMP, OP_TIX,
    OP_J, OP_JEQ, OP_JGT, OP_JLT, OP_JSUB, OP_RSUB,
    OP_LDA, OP_LDX, OP_LDL, OP_LDCH,
    OP_STA, OP_STX, OP_STL, OP_STSW, OP_STCH,
    OP_TD, OP_RD, OP_WD, OP_BAD
  } op_e;

  localparam int unsigned OpBits = $bits(op_e);

  // Signed compare of two words, giving the status code.
  function automatic logic [WordBits-1:0] cmp_code(input logic [WordBits-1:0] a,
                                                   input logic [WordBits-1:0] b);
    logic [WordBits-1:0] code;
    if (a == b) begin
      code = SwEqual;
    end else if ($signed(a) > $signed(b)) begin
      code = SwGreater;
    end else begin
      code = SwLess;
    end
    return code;
  endfunction

endpackage

>>> hw/rtl/sie_queue.sv
module sie_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned Depth   = 2;
  localparam int unsigned PtrBits = $clog2(Depth);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrBits:0]   count_q, count_d;

  assign full_o  = (count_q == (PtrBits+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update; push and pop are gated by the caller.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/sie_decode.sv
module sie_decode #(
  parameter int unsigned AddrBits = 15,
  parameter int unsigned InBits   = 80,
  parameter int unsigned EntBits  = 81
) (
  input  logic               tvalid_i,
  output logic               tready_o,
  input  logic [InBits-1:0]  tdata_i,
  input  logic               full_i,
  output logic               push_o,
  output logic [EntBits-1:0] entry_o
);

  import sie_pkg::*;

  localparam int unsigned OffTa    = 8;
  localparam int unsigned OffM     = OffTa + AddrBits;
  localparam int unsigned OffNpc   = OffM + WordBits;
  localparam int unsigned OffRbyte = OffNpc + AddrBits;
  localparam int unsigned OffTcode = OffRbyte + 8;

  logic [7:0] func;
  op_e        op;

  assign func = tdata_i[7:0];

  // Opcode byte to operation class.
  always_comb begin
    case (func)
      FuncAdd:  op = OP_ADD;
      FuncSub:  op = OP_SUB;
      FuncMul:  op = OP_MUL;
      FuncDiv:  op = OP_DIV;
      FuncAnd:  op = OP_AND;
      FuncOr:   op = OP_OR;
      FuncComp: op = OP_COMP;
      FuncTix:  op = OP_TIX;
      FuncJ:    op = OP_J;
      FuncJeq:  op = OP_JEQ;
      FuncJgt:  op = OP_JGT;
      FuncJlt:  op = OP_JLT;
      FuncJsub: op = OP_JSUB;
      FuncRsub: op = OP_RSUB;
      FuncLda:  op = OP_LDA;
      FuncLdx:  op = OP_LDX;
      FuncLdl:  op = OP_LDL;
      FuncLdch: op = OP_LDCH;
      FuncSta:  op = OP_STA;
      FuncStx:  op = OP_STX;
      FuncStl:  op = OP_STL;
      FuncStsw: op = OP_STSW;
      FuncStch: op = OP_STCH;
      FuncTd:   op = OP_TD;
      FuncRd:   op = OP_RD;
      FuncWd:   op = OP_WD;
      default:  op = OP_BAD;
    endcase
  end

  // Accept a beat whenever the queue has room.
  assign tready_o = !full_i;
  assign push_o   = tvalid_i && !full_i;

  // Queue entry, lowest bits first: op, target, operand, next pc, read byte, test code.
  assign entry_o = {tdata_i[OffTcode +: 3],
                    tdata_i[OffRbyte +: 8],
                    tdata_i[OffNpc +: AddrBits],
                    tdata_i[OffM +: WordBits],
                    tdata_i[OffTa +: AddrBits],
                    op};

endmodule

>>> hw/rtl/sie_execute.sv
module sie_execute #(
  parameter int unsigned AddrBits = 15,
  parameter int unsigned EntBits  = 81
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  logic [EntBits-1:0]  entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [AddrBits-1:0] new_pc_o,
  output logic [1:0]          store_kind_o,
  output logic [AddrBits-1:0] store_addr_o,
  output logic [23:0]         store_data_o,
  output logic                dev_write_o,
  output logic [7:0]          dev_id_o,
  output logic [7:0]          dev_data_o,
  output logic                dev_read_o,
  output logic                div_by_zero_o,
  output logic                bad_opcode_o
);

  import sie_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_e;

  localparam int unsigned CntBits = $clog2(WordBits);
  localparam int unsigned OffTa    = OpBits;
  localparam int unsigned OffM     = OffTa + AddrBits;
  localparam int unsigned OffNpc   = OffM + WordBits;
  localparam int unsigned OffRbyte = OffNpc + AddrBits;
  localparam int unsigned OffTcode = OffRbyte + 8;

  // Unpacked queue entry.
  op_e                 op;
  logic [AddrBits-1:0] ta;
  logic [WordBits-1:0] m;
  logic [AddrBits-1:0] npc;
  logic [7:0]          rbyte;
  logic [2:0]          tcode;
  logic [7:0]          mbyte;

  assign op    = op_e'(entry_i[OpBits-1:0]);
  assign ta    = entry_i[OffTa +: AddrBits];
  assign m     = entry_i[OffM +: WordBits];
  assign npc   = entry_i[OffNpc +: AddrBits];
  assign rbyte = entry_i[OffRbyte +: 8];
  assign tcode = entry_i[OffTcode +: 3];
  assign mbyte = m[WordBits-1 -: 8];

  state_e state_q, state_d;

  // Architectural registers.
  logic [WordBits-1:0] acc_q, acc_d;
  logic [WordBits-1:0] idx_q, idx_d;
  logic [WordBits-1:0] lnk_q, lnk_d;
  logic [WordBits-1:0] sw_q, sw_d;

  // Divider registers.
  logic [WordBits-1:0] rem_q, rem_d;
  logic [WordBits-1:0] quo_q, quo_d;
  logic [WordBits-1:0] dvs_q, dvs_d;
  logic                neg_q, neg_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [AddrBits-1:0] new_pc_q, new_pc_d;
  logic [1:0]          skind_q, skind_d;
  logic [AddrBits-1:0] saddr_q, saddr_d;
  logic [WordBits-1:0] sdata_q, sdata_d;
  logic                dwr_q, dwr_d;
  logic [7:0]          did_q, did_d;
  logic [7:0]          ddata_q, ddata_d;
  logic                drd_q, drd_d;
  logic                dz_q, dz_d;
  logic                bad_q, bad_d;

  logic [2*WordBits-1:0] prod;
  logic [WordBits-1:0]   idx_inc;
  logic [WordBits:0]     rem_shift;
  logic                  rem_ge;
  logic [WordBits-1:0]   acc_mag;
  logic [WordBits-1:0]   m_mag;

  assign prod      = {{WordBits{1'b0}}, acc_q} * {{WordBits{1'b0}}, m};
  assign idx_inc   = idx_q + 1'b1;
  assign acc_mag   = acc_q[WordBits-1] ? (~acc_q + 1'b1) : acc_q;
  assign m_mag     = m[WordBits-1] ? (~m + 1'b1) : m;
  assign rem_shift = {rem_q, quo_q[WordBits-1]};
  assign rem_ge    = (rem_shift >= {1'b0, dvs_q});

  // A new instruction leaves the queue while idle, once the output register frees up.
  assign pop_o = (state_q == ST_IDLE) && !empty_i && (!out_valid_q || out_ready_i);

  // Next-state logic for control, registers and the result beat.
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    idx_d       = idx_q;
    lnk_d       = lnk_q;
    sw_d        = sw_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dvs_d       = dvs_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    new_pc_d    = new_pc_q;
    skind_d     = skind_q;
    saddr_d     = saddr_q;
    sdata_d     = sdata_q;
    dwr_d       = dwr_q;
    did_d       = did_q;
    ddata_d     = ddata_q;
    drd_d       = drd_q;
    dz_d        = dz_q;
    bad_d       = bad_q;

    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          out_valid_d = 1'b1;
          new_pc_d    = npc;
          skind_d     = StoreNone;
          saddr_d     = '0;
          sdata_d     = '0;
          dwr_d       = 1'b0;
          did_d       = mbyte;
          ddata_d     = '0;
          drd_d       = 1'b0;
          dz_d        = 1'b0;
          bad_d       = 1'b0;
          case (op)
            OP_ADD:  acc_d = acc_q + m;
            OP_SUB:  acc_d = acc_q - m;
            OP_MUL:  acc_d = prod[WordBits-1:0];
            OP_DIV: begin
              if (m == '0) begin
                dz_d = 1'b1;
              end else begin
                // Hold the beat back until the quotient is known.
                out_valid_d = 1'b0;
                rem_d       = '0;
                quo_d       = acc_mag;
                dvs_d       = m_mag;
                neg_d       = acc_q[WordBits-1] ^ m[WordBits-1];
                cnt_d       = '0;
                state_d     = ST_DIV;
              end
            end
            OP_AND:  acc_d = acc_q & m;
            OP_OR:   acc_d = acc_q | m;
            OP_COMP: sw_d = cmp_code(acc_q, m);
            OP_TIX: begin
              idx_d = idx_inc;
              sw_d  = cmp_code(idx_inc, m);
            end
            OP_J:    new_pc_d = ta;
            OP_JEQ: begin
              if (sw_q == SwEqual) begin
                new_pc_d = ta;
              end
            end
            OP_JGT: begin
              if (sw_q == SwGreater) begin
                new_pc_d = ta;
              end
            end
            OP_JLT: begin
              if (sw_q == SwLess) begin
                new_pc_d = ta;
              end
            end
            OP_JSUB: begin
              lnk_d    = WordBits'(npc);
              new_pc_d = ta;
            end
            OP_RSUB: new_pc_d = lnk_q[AddrBits-1:0];
            OP_LDA:  acc_d = m;
            OP_LDX:  idx_d = m;
            OP_LDL:  lnk_d = m;
            OP_LDCH: acc_d = (acc_q & HighMask) | WordBits'(mbyte);
            OP_STA: begin
              skind_d = StoreWord;
              saddr_d = ta;
              sdata_d = acc_q;
            end
            OP_STX: begin
              skind_d = StoreWord;
              saddr_d = ta;
              sdata_d = idx_q;
            end
            OP_STL: begin
              skind_d = StoreWord;
              saddr_d = ta;
              sdata_d = lnk_q;
            end
            OP_STSW: begin
              skind_d = StoreWord;
              saddr_d = ta;
              sdata_d = sw_q;
            end
            OP_STCH: begin
              skind_d = StoreByte;
              saddr_d = ta;
              sdata_d = acc_q & LowMask;
            end
            OP_TD:   sw_d = WordBits'(tcode);
            OP_RD: begin
              acc_d = (acc_q & HighMask) | WordBits'(rbyte);
              drd_d = 1'b1;
            end
            OP_WD: begin
              dwr_d   = 1'b1;
              ddata_d = acc_q[7:0];
            end
            default: bad_d = 1'b1;
          endcase
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        rem_d = rem_ge ? WordBits'(rem_shift - {1'b0, dvs_q}) : rem_shift[WordBits-1:0];
        quo_d = {quo_q[WordBits-2:0], rem_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntBits'(WordBits - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // Apply the sign and release the beat prepared at issue.
        acc_d       = neg_q ? (~quo_q + 1'b1) : quo_q;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      idx_q       <= '0;
      lnk_q       <= '0;
      sw_q        <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      dvs_q       <= '0;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      new_pc_q    <= '0;
      skind_q     <= StoreNone;
      saddr_q     <= '0;
      sdata_q     <= '0;
      dwr_q       <= 1'b0;
      did_q       <= '0;
      ddata_q     <= '0;
      drd_q       <= 1'b0;
      dz_q        <= 1'b0;
      bad_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      idx_q       <= idx_d;
      lnk_q       <= lnk_d;
      sw_q        <= sw_d;
      rem_q       <= rem_d;
      quo_q       <= quo_d;
      dvs_q       <= dvs_d;
      neg_q       <= neg_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      new_pc_q    <= new_pc_d;
      skind_q     <= skind_d;
      saddr_q     <= saddr_d;
      sdata_q     <= sdata_d;
      dwr_q       <= dwr_d;
      did_q       <= did_d;
      ddata_q     <= ddata_d;
      drd_q       <= drd_d;
      dz_q        <= dz_d;
      bad_q       <= bad_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign new_pc_o      = new_pc_q;
  assign store_kind_o  = skind_q;
  assign store_addr_o  = saddr_q;
  assign store_data_o  = sdata_q;
  assign dev_write_o   = dwr_q;
  assign dev_id_o      = did_q;
  assign dev_data_o    = ddata_q;
  assign dev_read_o    = drd_q;
  assign div_by_zero_o = dz_q;
  assign bad_opcode_o  = bad_q;

endmodule

>>> hw/rtl/sic_instruction_execute.sv
// Execute stage of the 24-bit SIC machine. Each input beat carries one decoded
// instruction; each output beat carries its result: next PC, memory store request,
// device write and error flags. A, X, L and SW live here and reset to zero.
// A two-entry queue separates opcode decode from execution, so the input side
// keeps taking beats while a result waits. Every opcode but a DIV with a nonzero
// divisor gives one beat per cycle while the output is not stalled; such a DIV
// occupies the execute unit for setup, the bit-serial restoring divider and
// sign fix-up. Arithmetic wraps at 24 bits, compares are signed, and
// addresses are ADDR_BITS wide.
module sic_instruction_execute #(
  parameter int unsigned ADDR_BITS = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // func[8], target_addr[ADDR_BITS], operand_word[24], next_pc[ADDR_BITS],
  // dev_read_byte[8], dev_test_code[3], zero padding
  input  logic [((43 + 2*ADDR_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // new_pc[ADDR_BITS], store_kind[2], store_addr[ADDR_BITS], store_data[24],
  // dev_write[1], dev_id[8], dev_data[8], dev_read[1], div_by_zero[1],
  // bad_opcode[1], zero padding
  output logic [((46 + 2*ADDR_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  import sie_pkg::*;

  localparam int unsigned InBits  = ((43 + 2*ADDR_BITS + 7) / 8) * 8;
  localparam int unsigned OutBits = ((46 + 2*ADDR_BITS + 7) / 8) * 8;
  localparam int unsigned OutUsed = 46 + 2*ADDR_BITS;
  localparam int unsigned EntBits = OpBits + 2*ADDR_BITS + WordBits + 8 + 3;

  logic               push;
  logic               pop;
  logic               full;
  logic               empty;
  logic [EntBits-1:0] entry_in;
  logic [EntBits-1:0] entry_out;

  logic [ADDR_BITS-1:0] new_pc;
  logic [1:0]           store_kind;
  logic [ADDR_BITS-1:0] store_addr;
  logic [23:0]          store_data;
  logic                 dev_write;
  logic [7:0]           dev_id;
  logic [7:0]           dev_data;
  logic                 dev_read;
  logic                 div_by_zero;
  logic                 bad_opcode;

  // Front: accept beats and classify the opcode.
  sie_decode #(
    .AddrBits(ADDR_BITS),
    .InBits  (InBits),
    .EntBits (EntBits)
  ) u_decode (
    .tvalid_i(s_axis_tvalid),
    .tready_o(s_axis_tready),
    .tdata_i (s_axis_tdata),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry_in)
  );

  // Decoupling queue between decode and execute.
  sie_queue #(
    .Width(EntBits)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (entry_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (entry_out)
  );

  // Back: register file, divider and output register.
  sie_execute #(
    .AddrBits(ADDR_BITS),
    .EntBits (EntBits)
  ) u_execute (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .entry_i      (entry_out),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .new_pc_o     (new_pc),
    .store_kind_o (store_kind),
    .store_addr_o (store_addr),
    .store_data_o (store_data),
    .dev_write_o  (dev_write),
    .dev_id_o     (dev_id),
    .dev_data_o   (dev_data),
    .dev_read_o   (dev_read),
    .div_by_zero_o(div_by_zero),
    .bad_opcode_o (bad_opcode)
  );

  // Pack the result beat, first field in the lowest bits.
  assign m_axis_tdata = {{(OutBits - OutUsed){1'b0}},
                         bad_opcode, div_by_zero, dev_read, dev_data, dev_id,
                         dev_write, store_data, store_addr, store_kind, new_pc};

endmodule
